[sv/ghp_pkg.sv]
package ghp_pkg;

    localparam int ID_W    = 12;
    localparam int CNT_W   = 13;
    localparam int PART_W  = 6;
    localparam int PCNT_W  = 7;
    localparam int SCORE_W = 34;
    localparam int WT_W    = 21;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int NODE_DEPTH = 4096;
    localparam int EDGE_DEPTH = 4096;
    localparam int PART_MAX   = 64;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 2'd2;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] d;
    } t_wt_req;

    typedef struct packed {
        logic            done;
        logic [WT_W-1:0] weight;
    } t_wt_rsp;

endpackage

[sv/ghp_in_if.sv]
interface ghp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [11:0] node_id;
    logic [11:0] edge_id;

    modport source(output valid, output cmd, output node_id, output edge_id, input ready);
    modport sink(input valid, input cmd, input node_id, input edge_id, output ready);
endinterface

[sv/ghp_out_if.sv]
interface ghp_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] chosen_node;
    logic [5:0]  part_index;
    logic [33:0] score;
    logic        none_left;
    logic        last;

    modport source(output valid, output chosen_node, output part_index, output score,
                   output none_left, output last, input ready);
    modport sink(input valid, input chosen_node, input part_index, input score,
                 input none_left, input last, output ready);
endinterface

[sv/ghp_weight.sv]
module ghp_weight (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ghp_pkg::t_wt_req i_req,
    output ghp_pkg::t_wt_rsp o_rsp
);
    import ghp_pkg::*;

    localparam int DIV_STEPS = 43;
    localparam int SQ_STEPS  = 20;

    typedef enum logic [4:0] {
        W_IDLE = 5'b00001,
        W_K    = 5'b00010,
        W_DIV  = 5'b00100,
        W_SQ   = 5'b01000,
        W_FIN  = 5'b10000
    } t_wstate;

    t_wstate            r_st;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_dk;
    logic [3:0]         r_k;
    logic [42:0]        r_dv;
    logic [CNT_W-1:0]   r_rem;
    logic [30:0]        r_q;
    logic [30:0]        r_x;
    logic [19:0]        r_frac;
    logic [5:0]         r_cnt;
    logic               r_done;
    logic [WT_W-1:0]    r_wt;

    logic [CNT_W:0]     dk2;
    logic [CNT_W:0]     t;
    logic               qbit;
    logic [30:0]        nq;
    logic [61:0]        sq;
    logic [31:0]        y;
    logic [20:0]        rnd;

    always_comb begin
        dk2  = {r_dk, 1'b0};
        t    = {r_rem, r_dv[42]};
        qbit = (t >= {1'b0, r_dk});
        nq   = {r_q[29:0], qbit};
        sq   = 62'(r_x) * 62'(r_x);
        y    = sq[61:30];
        rnd  = {1'b0, r_frac} + 21'd8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= W_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                W_IDLE: begin
                    if (i_req.start) begin
                        r_n  <= i_req.n;
                        r_dk <= i_req.d;
                        r_k  <= '0;
                        r_st <= W_K;
                    end
                end
                W_K: begin
                    if (dk2 <= {1'b0, r_n}) begin
                        r_dk <= dk2[CNT_W-1:0];
                        r_k  <= r_k + 4'd1;
                    end else begin
                        r_dv  <= {r_n, 30'b0};
                        r_rem <= '0;
                        r_q   <= '0;
                        r_cnt <= '0;
                        r_st  <= W_DIV;
                    end
                end
                W_DIV: begin
                    r_rem <= qbit ? CNT_W'(t - {1'b0, r_dk}) : t[CNT_W-1:0];
                    r_q   <= nq;
                    r_dv  <= {r_dv[41:0], 1'b0};
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        r_x    <= nq;
                        r_frac <= '0;
                        r_cnt  <= '0;
                        r_st   <= W_SQ;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                W_SQ: begin
                    r_frac <= {r_frac[18:0], y[31]};
                    r_x    <= y[31] ? y[31:1] : y[30:0];
                    if (r_cnt == 6'(SQ_STEPS - 1)) begin
                        r_st <= W_FIN;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                W_FIN: begin
                    r_wt   <= WT_W'({r_k, 16'h0000}) + WT_W'(rnd[20:4]);
                    r_done <= 1'b1;
                    r_st   <= W_IDLE;
                end
                default: r_st <= W_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.weight = r_wt;

endmodule

[sv/greedy_hypergraph_partitioner.sv]
// Load stores a node/edge pair. Restart runs a clear sweep. Select adds a sweep on a part change
//   and can wait on the result port; misses of the one-entry weight cache go to the
//   shared log2 unit (k search, 43-step divider, 20 squarings).
// One item at a time; ready only while idle.
// Reset (i_rst_n low, synchronous) runs the same clear sweep as restart.
module greedy_hypergraph_partitioner #(
    parameter int MAX_INCIDENCES = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ghp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ghp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    ghp_in_if.sink                              i_in,
    ghp_out_if.source                           o_out
);
    import ghp_pkg::*;

    localparam int IAW  = $clog2(MAX_INCIDENCES);
    localparam int ITW  = $clog2(MAX_INCIDENCES + 1);
    localparam int DW   = ITW;
    localparam int CMPW = (DW > CNT_W) ? DW : CNT_W;

    typedef enum logic [16:0] {
        S_CLR    = 17'h00001,
        S_IDLE   = 17'h00002,
        S_LD     = 17'h00004,
        S_ZERO   = 17'h00008,
        S_SC_RD  = 17'h00010,
        S_SC_LK  = 17'h00020,
        S_SC_CHK = 17'h00040,
        S_SC_WT  = 17'h00080,
        S_SC_WR  = 17'h00100,
        S_ARG    = 17'h00200,
        S_TAKE   = 17'h00400,
        S_MK_RD  = 17'h00800,
        S_MK_WR  = 17'h01000,
        S_UPD    = 17'h02000,
        S_MOVE   = 17'h04000,
        S_EPC    = 17'h08000,
        S_OUT    = 17'h10000
    } t_state;

    t_state r_st;

    // configuration
    logic [CNT_W-1:0]  r_node_cnt, r_edge_cnt;
    logic [PCNT_W-1:0] r_part_cnt;
    logic [CNT_W-1:0]  eff_n, eff_e;
    logic [PCNT_W-1:0] eff_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cnt <= CNT_W'(NODE_DEPTH);
            r_edge_cnt <= CNT_W'(EDGE_DEPTH);
            r_part_cnt <= PCNT_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NODE_COUNT: r_node_cnt <= i_cfg_data;
                REG_EDGE_COUNT: r_edge_cnt <= i_cfg_data;
                REG_PART_COUNT: r_part_cnt <= i_cfg_data[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_n = (r_node_cnt > CNT_W'(NODE_DEPTH)) ? CNT_W'(NODE_DEPTH) : r_node_cnt;
        eff_e = (r_edge_cnt > CNT_W'(EDGE_DEPTH)) ? CNT_W'(EDGE_DEPTH) : r_edge_cnt;
        if (r_part_cnt > PCNT_W'(PART_MAX)) eff_p = PCNT_W'(PART_MAX);
        else if (r_part_cnt == '0)          eff_p = PCNT_W'(1);
        else                                eff_p = r_part_cnt;
    end

    // control registers
    logic [ITW-1:0]     r_itot, r_icnt;
    logic [CNT_W-1:0]   r_ncnt;
    logic [PART_W-1:0]  r_cur, r_res_part;
    logic [CNT_W-1:0]   r_pf;
    logic [ID_W-1:0]    r_v, r_pi, r_best, r_le;
    logic               r_pv, r_found;
    logic [SCORE_W-1:0] r_best_sc, r_sc;
    logic [CNT_W-1:0]   r_left;
    logic [WT_W-1:0]    r_w;
    logic               r_cval;
    logic [CNT_W-1:0]   r_cdeg;
    logic [WT_W-1:0]    r_cw;
    logic               r_ov;
    logic [ID_W-1:0]    r_o_node;
    logic [PART_W-1:0]  r_o_part;
    logic [SCORE_W-1:0] r_o_score;
    logic               r_o_none, r_o_last;
    logic [ID_W-1:0]    r_res_node;
    logic [SCORE_W-1:0] r_res_sc;
    logic               r_res_none, r_res_last;

    // memories
    logic [2*ID_W-1:0]  r_inc [MAX_INCIDENCES];
    logic [2*ID_W-1:0]  r_inc_q;
    logic [DW-1:0]      r_deg [EDGE_DEPTH];
    logic [DW-1:0]      r_deg_q;
    logic               r_inp [EDGE_DEPTH];
    logic               r_inp_q;
    logic               r_tkn [NODE_DEPTH];
    logic               r_tkn_q;
    logic [SCORE_W-1:0] r_scm [NODE_DEPTH];
    logic [SCORE_W-1:0] r_scm_q;

    logic               inc_we;
    logic [IAW-1:0]     inc_wa, inc_ra;
    logic               deg_we;
    logic [ID_W-1:0]    deg_wa, deg_ra;
    logic [DW-1:0]      deg_wd;
    logic               inp_we, inp_wd;
    logic [ID_W-1:0]    inp_wa, inp_ra;
    logic               tkn_we, tkn_wd;
    logic [ID_W-1:0]    tkn_wa, tkn_ra;
    logic               scm_we;
    logic [ID_W-1:0]    scm_wa, scm_ra;
    logic [SCORE_W-1:0] scm_wd;

    logic               acc;
    logic               ld_ok;
    logic [ID_W-1:0]    q_node, q_edge;
    logic               deg_ok, c_hit, skip;
    logic [SCORE_W:0]   sum;
    logic [19:0]        fill_prod;
    logic               out_free;
    t_wt_req            wreq;
    t_wt_rsp            wrsp;

    assign acc      = i_in.valid && i_in.ready;
    assign ld_ok    = ({1'b0, i_in.node_id} < eff_n) && ({1'b0, i_in.edge_id} < eff_e)
                      && (r_itot != ITW'(MAX_INCIDENCES));
    assign q_node   = r_inc_q[2*ID_W-1:ID_W];
    assign q_edge   = r_inc_q[ID_W-1:0];
    assign deg_ok   = (r_deg_q != '0) && (CMPW'(r_deg_q) <= CMPW'(eff_n));
    assign c_hit    = r_cval && (r_cdeg == CNT_W'(r_deg_q));
    assign skip     = ({1'b0, r_v} >= eff_n) || r_tkn_q || !r_inp_q;
    assign sum      = {1'b0, r_sc} + (SCORE_W + 1)'(r_w);
    assign fill_prod = 20'(r_pf) * 20'(eff_p);
    assign out_free = !r_ov || o_out.ready;

    assign wreq.start = (r_st == S_SC_CHK) && !skip && deg_ok && !c_hit;
    assign wreq.n     = eff_n;
    assign wreq.d     = CNT_W'(r_deg_q);

    ghp_weight u_weight (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (wreq),
        .o_rsp  (wrsp)
    );

    // memory port steering
    always_comb begin
        inc_we = (r_st == S_IDLE) && acc && (i_in.cmd == CMD_LOAD) && ld_ok;
        inc_wa = r_itot[IAW-1:0];
        inc_ra = r_icnt[IAW-1:0];

        deg_we = (r_st == S_CLR) || (r_st == S_LD);
        deg_wa = (r_st == S_CLR) ? r_ncnt[ID_W-1:0] : r_le;
        deg_wd = (r_st == S_CLR) ? '0 : r_deg_q + DW'(1);
        deg_ra = (r_st == S_IDLE) ? i_in.edge_id : q_edge;

        inp_we = (r_st == S_CLR) || (r_st == S_EPC) || ((r_st == S_MK_WR) && (q_node == r_best));
        inp_wa = (r_st == S_MK_WR) ? q_edge : r_ncnt[ID_W-1:0];
        inp_wd = (r_st == S_MK_WR);
        inp_ra = q_edge;

        tkn_we = (r_st == S_CLR) || (r_st == S_TAKE);
        tkn_wa = (r_st == S_TAKE) ? r_best : r_ncnt[ID_W-1:0];
        tkn_wd = (r_st == S_TAKE);
        tkn_ra = (r_st == S_ARG) ? r_ncnt[ID_W-1:0] : q_node;

        scm_we = ((r_st == S_ZERO) && (r_ncnt < eff_n)) || (r_st == S_SC_WR);
        scm_wa = (r_st == S_SC_WR) ? r_v : r_ncnt[ID_W-1:0];
        scm_wd = (r_st == S_SC_WR) ? (sum[SCORE_W] ? '1 : sum[SCORE_W-1:0]) : '0;
        scm_ra = (r_st == S_ARG) ? r_ncnt[ID_W-1:0] : q_node;
    end

    always_ff @(posedge i_clk) begin
        if (inc_we) r_inc[inc_wa] <= {i_in.node_id, i_in.edge_id};
        r_inc_q <= r_inc[inc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) r_deg[deg_wa] <= deg_wd;
        r_deg_q <= r_deg[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (inp_we) r_inp[inp_wa] <= inp_wd;
        r_inp_q <= r_inp[inp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tkn_we) r_tkn[tkn_wa] <= tkn_wd;
        r_tkn_q <= r_tkn[tkn_ra];
    end

    always_ff @(posedge i_clk) begin
        if (scm_we) r_scm[scm_wa] <= scm_wd;
        r_scm_q <= r_scm[scm_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_CLR;
            r_ncnt <= '0;
            r_itot <= '0;
            r_cur  <= '0;
            r_pf   <= '0;
            r_ov   <= 1'b0;
            r_cval <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            // drop the held beat once it is taken
            if (r_ov && o_out.ready && (r_st != S_OUT)) r_ov <= 1'b0;

            unique case (r_st)
                S_CLR: begin
                    // sweep taken, edge set and degree back to zero
                    r_ncnt <= r_ncnt + CNT_W'(1);
                    if (r_ncnt[ID_W-1:0] == '1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (acc) begin
                        case (i_in.cmd)
                            CMD_LOAD: begin
                                if (ld_ok) begin
                                    r_itot <= r_itot + ITW'(1);
                                    r_le   <= i_in.edge_id;
                                    r_st   <= S_LD;
                                end
                            end
                            CMD_SELECT: begin
                                r_ncnt <= '0;
                                r_cval <= 1'b0;
                                r_st   <= S_ZERO;
                            end
                            CMD_RESTART: begin
                                r_ncnt <= '0;
                                r_itot <= '0;
                                r_cur  <= '0;
                                r_pf   <= '0;
                                r_st   <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LD: r_st <= S_IDLE;
                S_ZERO: begin
                    if (r_ncnt < eff_n) begin
                        r_ncnt <= r_ncnt + CNT_W'(1);
                    end else begin
                        r_icnt <= '0;
                        r_st   <= S_SC_RD;
                    end
                end
                S_SC_RD: begin
                    if (r_icnt == r_itot) begin
                        r_ncnt    <= '0;
                        r_pv      <= 1'b0;
                        r_found   <= 1'b0;
                        r_left    <= '0;
                        r_best    <= '0;
                        r_best_sc <= '0;
                        r_st      <= S_ARG;
                    end else begin
                        r_st <= S_SC_LK;
                    end
                end
                S_SC_LK: begin
                    r_v  <= q_node;
                    r_st <= S_SC_CHK;
                end
                S_SC_CHK: begin
                    r_sc <= r_scm_q;
                    if (skip) begin
                        r_icnt <= r_icnt + ITW'(1);
                        r_st   <= S_SC_RD;
                    end else if (!deg_ok) begin
                        r_w  <= '0;
                        r_st <= S_SC_WR;
                    end else if (c_hit) begin
                        r_w  <= r_cw;
                        r_st <= S_SC_WR;
                    end else begin
                        r_cdeg <= CNT_W'(r_deg_q);
                        r_st   <= S_SC_WT;
                    end
                end
                S_SC_WT: begin
                    if (wrsp.done) begin
                        r_w    <= wrsp.weight;
                        r_cw   <= wrsp.weight;
                        r_cval <= 1'b1;
                        r_st   <= S_SC_WR;
                    end
                end
                S_SC_WR: begin
                    r_icnt <= r_icnt + ITW'(1);
                    r_st   <= S_SC_RD;
                end
                S_ARG: begin
                    // read one node a cycle, compare it in the next cycle
                    if (r_ncnt < eff_n) begin
                        r_pi   <= r_ncnt[ID_W-1:0];
                        r_pv   <= 1'b1;
                        r_ncnt <= r_ncnt + CNT_W'(1);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && !r_tkn_q) begin
                        r_left <= r_left + CNT_W'(1);
                        if (!r_found || (r_scm_q > r_best_sc)) begin
                            r_found   <= 1'b1;
                            r_best    <= r_pi;
                            r_best_sc <= r_scm_q;
                        end
                    end
                    if ((r_ncnt == eff_n) && !r_pv) begin
                        if (r_found) begin
                            r_st <= S_TAKE;
                        end else begin
                            r_res_node <= '0;
                            r_res_part <= '0;
                            r_res_sc   <= '0;
                            r_res_none <= 1'b1;
                            r_res_last <= 1'b0;
                            r_st       <= S_OUT;
                        end
                    end
                end
                S_TAKE: begin
                    r_icnt <= '0;
                    r_st   <= S_MK_RD;
                end
                S_MK_RD: begin
                    if (r_icnt == r_itot) r_st <= S_UPD;
                    else                  r_st <= S_MK_WR;
                end
                S_MK_WR: begin
                    r_icnt <= r_icnt + ITW'(1);
                    r_st   <= S_MK_RD;
                end
                S_UPD: begin
                    if (r_pf != '1) r_pf <= r_pf + CNT_W'(1);
                    r_res_node <= r_best;
                    r_res_part <= r_cur;
                    r_res_sc   <= r_best_sc;
                    r_res_none <= 1'b0;
                    r_res_last <= (r_left == CNT_W'(1));
                    r_st       <= S_MOVE;
                end
                S_MOVE: begin
                    // fill >= n/p + 1 is the same as fill * p > n
                    if ((fill_prod > 20'(eff_n))
                        && (({1'b0, r_cur} + PCNT_W'(1)) < eff_p)) begin
                        r_cur  <= r_cur + PART_W'(1);
                        r_pf   <= '0;
                        r_ncnt <= '0;
                        r_st   <= S_EPC;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_EPC: begin
                    r_ncnt <= r_ncnt + CNT_W'(1);
                    if (r_ncnt[ID_W-1:0] == '1) r_st <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov      <= 1'b1;
                        r_o_node  <= r_res_node;
                        r_o_part  <= r_res_part;
                        r_o_score <= r_res_sc;
                        r_o_none  <= r_res_none;
                        r_o_last  <= r_res_last;
                        r_st      <= S_IDLE;
                    end
                end
                default: r_st <= S_CLR;
            endcase
        end
    end

    assign i_in.ready        = (r_st == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.chosen_node = r_o_node;
    assign o_out.part_index  = r_o_part;
    assign o_out.score       = r_o_score;
    assign o_out.none_left   = r_o_none;
    assign o_out.last        = r_o_last;

endmodule

[sv/ghp_checker.sv]
module ghp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_chosen_node,
    input logic [5:0]  i_part_index,
    input logic [33:0] i_score,
    input logic        i_none_left,
    input logic        i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_chosen_node)
            && $stable(i_score) && $stable(i_part_index))
        else $error("result beat changed while stalled");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_none_left |-> i_chosen_node == 12'd0 && i_score == 34'd0
            && i_part_index == 6'd0 && !i_last)
        else $error("empty result carries nonzero fields");

    a_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after accept");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("ports active right after reset");

endmodule

bind greedy_hypergraph_partitioner ghp_checker u_ghp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_chosen_node(o_out.chosen_node),
    .i_part_index (o_out.part_index),
    .i_score      (o_out.score),
    .i_none_left  (o_out.none_left),
    .i_last       (o_out.last)
);
